// ===== rtl/core/sbox_linear_correlation_assert.svh =====
// ---------------------------------------------------------------------------
// S-box linear correlation: assertion macros
// Wraps concurrent assertions so that synthesis sees nothing of them.
// ---------------------------------------------------------------------------
`ifndef SBOX_LINEAR_CORRELATION_ASSERT_SVH
`define SBOX_LINEAR_CORRELATION_ASSERT_SVH
`ifndef SYNTHESIS
`define SLC_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("slc: assertion failed");
`define SLC_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("slc: assertion failed");
`else
`define SLC_ASSERT(label, clk, rst_n, prop)
`define SLC_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/core/slc_pkg.sv =====
// ---------------------------------------------------------------------------
// S-box linear correlation: shared package
// Sizes, codes, the cell link type and small helper functions.
// ---------------------------------------------------------------------------
`default_nettype none
package slc_pkg;

	localparam int MAX_IN_BITS  = 8;
	localparam int MAX_OUT_BITS = 8;

	localparam int X_W         = MAX_IN_BITS;
	localparam int S_W         = MAX_OUT_BITS;
	localparam int FIELD_W     = 8;
	localparam int STORE_DEPTH = 1 << MAX_IN_BITS;
	localparam int CHAIN_LEN   = (MAX_IN_BITS > MAX_OUT_BITS) ? MAX_IN_BITS : MAX_OUT_BITS;
	localparam int BITS_W      = $clog2(CHAIN_LEN + 1);
	localparam int ACC_W       = MAX_IN_BITS + 2;
	localparam int CORR_W      = 10;
	localparam int CORR_MAX    = 511;
	localparam int CORR_MIN    = -512;
	localparam int CFG_W       = 4;
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;

	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;

	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_VALUE = 2'd1;
	localparam logic [1:0] ERR_RANGE = 2'd2;

	localparam logic REG_INPUT_BITS  = 1'b0;
	localparam logic REG_OUTPUT_BITS = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RDWAIT,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	// One step of the parity chain: all four words shift right by one bit per cell.
	typedef struct packed {
		logic           valid;
		logic           last;
		logic           par;
		logic [X_W-1:0] x;
		logic [X_W-1:0] a;
		logic [S_W-1:0] s;
		logic [S_W-1:0] b;
	} cell_bus_t;

	function automatic logic [BITS_W-1:0] clamp_bits(logic [CFG_W-1:0] v, int maxv);
		logic [BITS_W-1:0] r;
		r = BITS_W'(maxv);
		if (v == '0) begin
			r = BITS_W'(1);
		end else if (int'(v) <= maxv) begin
			r = BITS_W'(v);
		end
		return r;
	endfunction

	// True when v is below 2^nbits.
	function automatic logic fits_bits(logic [FIELD_W-1:0] v, logic [BITS_W-1:0] nbits);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < FIELD_W; i++) begin
			if (v[i] && (i >= int'(nbits))) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

	function automatic logic [X_W-1:0] low_mask(logic [BITS_W-1:0] nbits);
		logic [X_W-1:0] m;
		for (int i = 0; i < X_W; i++) begin
			m[i] = (i < int'(nbits));
		end
		return m;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sbox_linear_correlation.sv =====
// ---------------------------------------------------------------------------
// S-box linear correlation
// Stores an S-box table and answers linear approximation queries on it.
// ---------------------------------------------------------------------------
//
//   Channel    Handshake                    Payload
//   --------   --------------------------   --------------------------------
//   request    req_valid / req_stall        req_type, table_index,
//                                           entry_value, in_mask, out_mask
//   response   rsp_valid / rsp_stall        correlation, entry_out, error_code
//   config     APB psel/penable/pwrite      input_bits at 0x0, output_bits at 0x4
//
// One item is worked on at a time. A write passes through the check and result
// states, a read through check, read wait and result. A query scans 2^input_bits
// entries: the store's single read port delivers one entry per cycle into a
// chain of CHAIN_LEN parity cells, and the chain must drain before the sum is
// final. The response sits in an output register, so a new item is accepted
// while an earlier response is still stalled. Reset clears control state and
// sets both configuration registers to 8; the table itself is not cleared.
//
`default_nettype none
`include "sbox_linear_correlation_assert.svh"
module sbox_linear_correlation
	import slc_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// request channel
	input  wire logic                      req_valid,
	output logic                           req_stall,
	input  wire logic [1:0]                req_type,
	input  wire logic [FIELD_W-1:0]        table_index,
	input  wire logic [FIELD_W-1:0]        entry_value,
	input  wire logic [FIELD_W-1:0]        in_mask,
	input  wire logic [FIELD_W-1:0]        out_mask,
	// response channel
	output logic                           rsp_valid,
	input  wire logic                      rsp_stall,
	output logic signed [CORR_W-1:0]       correlation,
	output logic [FIELD_W-1:0]             entry_out,
	output logic [1:0]                     error_code,
	// configuration port
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [APB_AW-1:0]         paddr,
	input  wire logic [APB_DW-1:0]         pwdata,
	output logic      [APB_DW-1:0]         prdata,
	output logic                           pready
);

	localparam logic signed [ACC_W-1:0] ACC_INC = ACC_W'(1);
	localparam logic signed [ACC_W-1:0] ACC_DEC = ACC_W'(-1);

	// Configuration registers and their clamped values.
	logic [CFG_W-1:0]  cfg_in_bits_q;
	logic [CFG_W-1:0]  cfg_out_bits_q;
	logic [BITS_W-1:0] ib;
	logic [BITS_W-1:0] ob;
	logic [X_W-1:0]    lim_mask;

	// Sequencer state and the item being worked on.
	state_t             state_q;
	state_t             state_d;
	logic [1:0]         req_q;
	logic [FIELD_W-1:0] idx_q;
	logic [FIELD_W-1:0] val_q;
	logic [FIELD_W-1:0] imask_q;
	logic [FIELD_W-1:0] omask_q;
	logic [1:0]         chk_err;

	// Result being built, and the response register.
	logic signed [CORR_W-1:0] res_corr_q;
	logic [FIELD_W-1:0]       res_entry_q;
	logic [1:0]               res_err_q;
	logic                     rsp_valid_q;
	logic signed [CORR_W-1:0] rsp_corr_q;
	logic [FIELD_W-1:0]       rsp_entry_q;
	logic [1:0]               rsp_err_q;

	// Scan, store and chain.
	logic [X_W-1:0]       x_q;
	logic                 head_valid_s1;
	logic                 head_last_s1;
	logic [X_W-1:0]       head_x_s1;
	logic                 mem_we;
	logic                 mem_re;
	logic [X_W-1:0]       mem_raddr;
	logic [FIELD_W-1:0]   mem_rdata;
	logic                 scan_issue;
	logic                 rsp_load;
	logic                 req_accept;
	logic                 cfg_write;
	cell_bus_t            chain [0:CHAIN_LEN];
	cell_bus_t            tail;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     acc_done_q;
	logic signed [CORR_W-1:0] corr_sat;

	// -----------------------------------------------------------------------
	// Configuration port. Only address bit 2 selects a register.
	// -----------------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_in_bits_q  <= CFG_RESET;
			cfg_out_bits_q <= CFG_RESET;
		end else if (cfg_write) begin
			if (paddr[2] == REG_OUTPUT_BITS) begin
				cfg_out_bits_q <= pwdata[CFG_W-1:0];
			end else begin
				cfg_in_bits_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_INPUT_BITS) ? APB_DW'(cfg_in_bits_q)
		: APB_DW'(cfg_out_bits_q);

	assign ib       = clamp_bits(cfg_in_bits_q, MAX_IN_BITS);
	assign ob       = clamp_bits(cfg_out_bits_q, MAX_OUT_BITS);
	assign lim_mask = low_mask(ib);

	// -----------------------------------------------------------------------
	// Request checks, done on the latched item. The index check comes before
	// the value check on a write.
	// -----------------------------------------------------------------------
	always_comb begin
		case (req_q)
			REQ_WRITE: begin
				if (!fits_bits(idx_q, ib)) begin
					chk_err = ERR_RANGE;
				end else if (!fits_bits(val_q, ob)) begin
					chk_err = ERR_VALUE;
				end else begin
					chk_err = ERR_OK;
				end
			end
			REQ_READ: begin
				chk_err = fits_bits(idx_q, ib) ? ERR_OK : ERR_RANGE;
			end
			REQ_QUERY: begin
				chk_err = (fits_bits(imask_q, ib) && fits_bits(omask_q, ob)) ? ERR_OK
					: ERR_RANGE;
			end
			default: begin
				chk_err = ERR_RANGE;
			end
		endcase
	end

	// -----------------------------------------------------------------------
	// Sequencer: next state.
	// -----------------------------------------------------------------------
	assign req_accept = req_valid & ~req_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_accept) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (chk_err != ERR_OK) begin
					state_d = ST_RESULT;
				end else begin
					case (req_q)
						REQ_READ:  state_d = ST_RDWAIT;
						REQ_QUERY: state_d = ST_SCAN;
						default:   state_d = ST_RESULT;
					endcase
				end
			end
			ST_RDWAIT: begin
				state_d = ST_RESULT;
			end
			ST_SCAN: begin
				if (x_q == lim_mask) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (acc_done_q) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// -----------------------------------------------------------------------
	// Sequencer: outputs.
	// -----------------------------------------------------------------------
	always_comb begin
		req_stall  = 1'b1;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_raddr  = x_q;
		scan_issue = 1'b0;
		rsp_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
			end
			ST_CHECK: begin
				mem_raddr = X_W'(idx_q);
				mem_we    = (req_q == REQ_WRITE) && (chk_err == ERR_OK);
				mem_re    = (req_q == REQ_READ) && (chk_err == ERR_OK);
			end
			ST_SCAN: begin
				mem_re     = 1'b1;
				scan_issue = 1'b1;
			end
			ST_RESULT: begin
				rsp_load = ~rsp_valid_q | ~rsp_stall;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// The latched item needs no reset: it is read only after an acceptance.
	always_ff @(posedge clk) begin
		if (req_accept) begin
			req_q   <= req_type;
			idx_q   <= table_index;
			val_q   <= entry_value;
			imask_q <= in_mask;
			omask_q <= out_mask;
		end
	end

	// -----------------------------------------------------------------------
	// Table store.
	// -----------------------------------------------------------------------
	slc_store u_store (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (X_W'(idx_q)),
		.wdata   (val_q),
		.re      (mem_re),
		.raddr   (mem_raddr),
		.rd_data (mem_rdata)
	);

	// -----------------------------------------------------------------------
	// Scan counter and the head of the chain, aligned with the store's read
	// latency.
	// -----------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			x_q <= '0;
		end else if (scan_issue) begin
			x_q <= x_q + X_W'(1);
		end
		head_x_s1 <= x_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_s1 <= 1'b0;
			head_last_s1  <= 1'b0;
		end else begin
			head_valid_s1 <= scan_issue;
			head_last_s1  <= scan_issue && (x_q == lim_mask);
		end
	end

	assign chain[0] = '{valid: head_valid_s1, last: head_last_s1, par: 1'b0,
		x: head_x_s1, a: X_W'(imask_q), s: S_W'(mem_rdata), b: S_W'(omask_q)};

	// Each cell folds one bit position of both masked words into the parity.
	for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_cell
		slc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.prev_bus (chain[k]),
			.next_bus (chain[k+1])
		);
	end

	assign tail = chain[CHAIN_LEN];

	// -----------------------------------------------------------------------
	// Correlation accumulator: +1 where the two parities agree, -1 otherwise.
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			acc_done_q <= 1'b0;
		end else if (state_q == ST_CHECK) begin
			acc_q      <= '0;
			acc_done_q <= 1'b0;
		end else if (tail.valid) begin
			acc_q      <= acc_q + (tail.par ? ACC_DEC : ACC_INC);
			acc_done_q <= acc_done_q | tail.last;
		end
	end

	always_comb begin
		if (int'(acc_q) > CORR_MAX) begin
			corr_sat = CORR_W'(CORR_MAX);
		end else if (int'(acc_q) < CORR_MIN) begin
			corr_sat = CORR_W'(CORR_MIN);
		end else begin
			corr_sat = CORR_W'(acc_q);
		end
	end

	// -----------------------------------------------------------------------
	// Result assembly.
	// -----------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			ST_CHECK: begin
				res_corr_q  <= '0;
				res_entry_q <= '0;
				res_err_q   <= chk_err;
			end
			ST_RDWAIT: begin
				res_entry_q <= mem_rdata;
			end
			ST_DRAIN: begin
				if (acc_done_q) begin
					res_corr_q <= corr_sat;
				end
			end
			default: begin
				res_err_q <= res_err_q;
			end
		endcase
	end

	// Response register: a loaded response waits here until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_corr_q  <= res_corr_q;
			rsp_entry_q <= res_entry_q;
			rsp_err_q   <= res_err_q;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign correlation = rsp_corr_q;
	assign entry_out   = rsp_entry_q;
	assign error_code  = rsp_err_q;

	// -----------------------------------------------------------------------
	// Assertions.
	// -----------------------------------------------------------------------
	`SLC_ASSERT(a_accept_to_check, clk, arst_n, req_accept |=> (state_q == ST_CHECK))
	`SLC_ASSERT(a_rsp_from_result, clk, arst_n, $rose(rsp_valid) |-> ($past(state_q) == ST_RESULT))
	`SLC_ASSERT(a_head_in_scan, clk, arst_n, head_valid_s1 |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
	`SLC_ASSERT(a_error_zero_corr, clk, arst_n, (state_q == ST_RESULT && res_err_q != ERR_OK) |-> (res_corr_q == '0))
	`SLC_ASSERT_ALWAYS(a_reset_no_rsp, clk, !arst_n |=> !rsp_valid)

endmodule
`default_nettype wire

// ===== rtl/core/slc_cell.sv =====
// ---------------------------------------------------------------------------
// S-box linear correlation: parity cell
// Folds the low bit of both masked words into the running parity and
// hands the shifted words to the next cell.
// ---------------------------------------------------------------------------
`default_nettype none
module slc_cell
	import slc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  cell_bus_t  prev_bus,
	output cell_bus_t  next_bus
);

	logic           valid_q;
	logic           last_q;
	logic           par_q;
	logic [X_W-1:0] x_q;
	logic [X_W-1:0] a_q;
	logic [S_W-1:0] s_q;
	logic [S_W-1:0] b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			valid_q <= prev_bus.valid;
			last_q  <= prev_bus.valid & prev_bus.last;
		end
	end

	always_ff @(posedge clk) begin
		par_q <= prev_bus.par ^ (prev_bus.x[0] & prev_bus.a[0]) ^ (prev_bus.s[0] & prev_bus.b[0]);
		x_q   <= prev_bus.x >> 1;
		a_q   <= prev_bus.a >> 1;
		s_q   <= prev_bus.s >> 1;
		b_q   <= prev_bus.b >> 1;
	end

	assign next_bus = '{valid: valid_q, last: last_q, par: par_q,
		x: x_q, a: a_q, s: s_q, b: b_q};

endmodule
`default_nettype wire

// ===== rtl/core/slc_store.sv =====
// ---------------------------------------------------------------------------
// S-box linear correlation: table store
// One write port and one registered read port over the S-box entries.
// ---------------------------------------------------------------------------
`default_nettype none
module slc_store
	import slc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               we,
	input  wire logic [X_W-1:0]     waddr,
	input  wire logic [FIELD_W-1:0] wdata,
	input  wire logic               re,
	input  wire logic [X_W-1:0]     raddr,
	output logic      [FIELD_W-1:0] rd_data
);

	logic [FIELD_W-1:0] mem [STORE_DEPTH];
	logic [FIELD_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_data_q <= mem[raddr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// ===== tb/sv/tb_sbox_linear_correlation.sv =====
// ----------------------------------------------------------------------------
// S-box linear correlation testbench
// Drives writes, reads, correlation queries and junk requests into the block
// through several register settings. Every response is checked against a
// local copy of the table and a correlation computed in the testbench.
// ----------------------------------------------------------------------------
module tb_sbox_linear_correlation
	import slc_pkg::*;
;

	// The package names three request kinds; the fourth encoding is junk that
	// the block must reject with a range error.
	localparam logic [1:0] REQ_JUNK = 2'd3;

	// A query at eight input bits is the slowest item. The receiver's long
	// hold-off adds LONG_HOLD on top of that, and the limit takes the sum
	// several times over.
	localparam int LONG_HOLD   = 600;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_WAIT  = 300;
	localparam int SETTLE_WAIT = 4;

	typedef struct {
		logic [1:0]         kind;
		logic [FIELD_W-1:0] index;
		logic [FIELD_W-1:0] value;
		logic [FIELD_W-1:0] imask;
		logic [FIELD_W-1:0] omask;
	} sbox_request_t;

	typedef struct {
		logic signed [CORR_W-1:0] corr;
		logic [FIELD_W-1:0]       entry;
		logic [1:0]               err;
	} sbox_answer_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;

	logic                     req_valid = 1'b0;
	logic                     req_stall;
	logic [1:0]               req_type = REQ_WRITE;
	logic [FIELD_W-1:0]       table_index = '0;
	logic [FIELD_W-1:0]       entry_value = '0;
	logic [FIELD_W-1:0]       in_mask = '0;
	logic [FIELD_W-1:0]       out_mask = '0;

	logic                     rsp_valid;
	logic                     rsp_stall = 1'b0;
	logic signed [CORR_W-1:0] correlation;
	logic [FIELD_W-1:0]       entry_out;
	logic [1:0]               error_code;

	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [APB_AW-1:0]        paddr = '0;
	logic [APB_DW-1:0]        pwdata = '0;
	logic [APB_DW-1:0]        prdata;
	logic                     pready;

	// Requests waiting to be offered, and answers waiting to be seen.
	sbox_request_t request_backlog[$];
	sbox_answer_t  expected_answers[$];
	sbox_request_t outgoing;
	sbox_answer_t  oldest_answer;

	// The testbench's own image of the table and of the two registers. The
	// image follows accepted requests; plan_written follows generated ones,
	// so that the generator never asks for an entry that was never stored.
	logic [FIELD_W-1:0] sbox_image [STORE_DEPTH];
	bit                 plan_written [STORE_DEPTH];
	logic [CFG_W-1:0]   in_bits_reg = CFG_RESET;
	logic [CFG_W-1:0]   out_bits_reg = CFG_RESET;

	int send_idle_pct = 35;
	int recv_idle_pct = 35;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int answers_seen = 0;
	int error_count = 0;
	int quiet_cycles = 0;

	sbox_linear_correlation DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_type    (req_type),
		.table_index (table_index),
		.entry_value (entry_value),
		.in_mask     (in_mask),
		.out_mask    (out_mask),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.correlation (correlation),
		.entry_out   (entry_out),
		.error_code  (error_code),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Register values outside 1..ceiling are pulled back into range before use.
	function automatic int used_bits(logic [CFG_W-1:0] v, int ceiling);
		if (v == '0) begin
			return 1;
		end
		if (int'(v) > ceiling) begin
			return ceiling;
		end
		return int'(v);
	endfunction

	// Works out the answer to one accepted request and applies a write to the
	// table image. A query sums +1 for every index whose masked input parity
	// equals the masked parity of its entry, and -1 for every other index.
	function automatic sbox_answer_t apply_request(sbox_request_t r);
		sbox_answer_t       a;
		int                 in_lim;
		int                 out_lim;
		int                 sum;
		logic [FIELD_W-1:0] s;
		in_lim = 1 << used_bits(in_bits_reg, MAX_IN_BITS);
		out_lim = 1 << used_bits(out_bits_reg, MAX_OUT_BITS);
		a.corr = '0;
		a.entry = '0;
		a.err = ERR_OK;
		sum = 0;
		case (r.kind)
			REQ_WRITE: begin
				// The index is checked before the value.
				if (r.index >= in_lim) begin
					a.err = ERR_RANGE;
				end else if (r.value >= out_lim) begin
					a.err = ERR_VALUE;
				end else begin
					sbox_image[r.index] = r.value;
				end
			end
			REQ_READ: begin
				if (r.index >= in_lim) begin
					a.err = ERR_RANGE;
				end else begin
					a.entry = sbox_image[r.index];
				end
			end
			REQ_QUERY: begin
				if (r.imask >= in_lim || r.omask >= out_lim) begin
					a.err = ERR_RANGE;
				end else begin
					for (int x = 0; x < in_lim; x++) begin
						s = sbox_image[x];
						if (^(FIELD_W'(x) & r.imask) == ^(s & r.omask)) begin
							sum++;
						end else begin
							sum--;
						end
					end
					if (sum > CORR_MAX) begin
						sum = CORR_MAX;
					end
					if (sum < CORR_MIN) begin
						sum = CORR_MIN;
					end
					a.corr = CORR_W'(sum);
				end
			end
			default: begin
				a.err = ERR_RANGE;
			end
		endcase
		return a;
	endfunction

	// Queues a request and notes which entries it will have stored by the
	// time the requests behind it run.
	function automatic void queue_request(sbox_request_t r, int ib, int ob);
		if (r.kind == REQ_WRITE && r.index < (1 << ib) && r.value < (1 << ob)) begin
			plan_written[r.index] = 1'b1;
		end
		request_backlog.insert(request_backlog.size(), r);
	endfunction

	// Builds one random request for the given effective widths. While part of
	// the table below 2^ib is still empty, most requests fill it, so that
	// in-range queries become possible soon. Reads and in-range queries only
	// touch stored entries.
	function automatic sbox_request_t make_request(int ib, int ob);
		sbox_request_t r;
		int            in_lim;
		int            out_lim;
		int            offset;
		int            slot;
		int            empty_slot;
		int            known_slot;
		int            roll;
		in_lim = 1 << ib;
		out_lim = 1 << ob;
		r.kind = REQ_WRITE;
		r.index = FIELD_W'($urandom);
		r.value = FIELD_W'($urandom);
		r.imask = FIELD_W'($urandom);
		r.omask = FIELD_W'($urandom);
		empty_slot = -1;
		known_slot = -1;
		offset = $urandom_range(in_lim - 1);
		for (int k = 0; k < in_lim; k++) begin
			slot = (offset + k) % in_lim;
			if (!plan_written[slot] && empty_slot < 0) begin
				empty_slot = slot;
			end
			if (plan_written[slot] && known_slot < 0) begin
				known_slot = slot;
			end
		end
		roll = $urandom_range(99);
		if (empty_slot >= 0 && roll < 80) begin
			r.index = FIELD_W'(empty_slot);
			r.value = FIELD_W'($urandom_range(out_lim - 1));
			return r;
		end
		roll = $urandom_range(99);
		if (roll < 25) begin
			if ($urandom_range(3) != 0) begin
				r.index = FIELD_W'($urandom_range(in_lim - 1));
			end
			if ($urandom_range(3) != 0) begin
				r.value = FIELD_W'($urandom_range(out_lim - 1));
			end
		end else if (roll < 45) begin
			r.kind = REQ_READ;
			if (in_lim < STORE_DEPTH && $urandom_range(3) == 0) begin
				r.index = FIELD_W'($urandom_range(STORE_DEPTH - 1, in_lim));
			end else if (known_slot >= 0) begin
				r.index = FIELD_W'(known_slot);
			end else begin
				// Nothing stored yet below the limit: store something instead.
				r.kind = REQ_WRITE;
				r.index = FIELD_W'(empty_slot);
				r.value = FIELD_W'($urandom_range(out_lim - 1));
			end
		end else if (roll < 90) begin
			r.kind = REQ_QUERY;
			if (empty_slot < 0 && ($urandom_range(7) != 0
					|| (in_lim == STORE_DEPTH && out_lim == STORE_DEPTH))) begin
				r.imask = FIELD_W'($urandom_range(in_lim - 1));
				r.omask = FIELD_W'($urandom_range(out_lim - 1));
			end else if (in_lim < STORE_DEPTH) begin
				r.imask = FIELD_W'($urandom_range(STORE_DEPTH - 1, in_lim));
			end else if (out_lim < STORE_DEPTH) begin
				r.omask = FIELD_W'($urandom_range(STORE_DEPTH - 1, out_lim));
			end else begin
				r.kind = REQ_WRITE;
				r.index = FIELD_W'(empty_slot);
				r.value = FIELD_W'($urandom_range(out_lim - 1));
			end
		end else begin
			r.kind = REQ_JUNK;
		end
		return r;
	endfunction

	// One register write: a setup phase, then an access phase that completes
	// on the first edge with pready high.
	task automatic write_register(input logic [APB_AW-1:0] addr, input logic [CFG_W-1:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= APB_DW'(v);
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Waits until every queued request has been taken and answered. State is
	// read at the falling edge, clear of the updates made at the rising one.
	task automatic wait_drained();
		@(negedge clk);
		while (request_backlog.size() != 0 || req_valid || expected_answers.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Stimulus. Each phase sets both registers while the block is idle, then
	// queues its requests and waits for all of them to be answered. Phase 0
	// is the directed part; the others are random. The register settings
	// include zero and fifteen, which the block pulls back to its limits,
	// and most phases use few input bits so that queries stay short.
	initial begin
		int phase_in  [11] = '{2, 1, 0, 3, 15, 4, 8, 5, 2, 6, 7};
		int phase_out [11] = '{3, 1, 15, 2, 0, 4, 8, 7, 8, 1, 5};
		int phase_len [11] = '{0, 80, 80, 100, 100, 120, 250, 150, 100, 100, 60};
		int ib;
		int ob;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < 11; p++) begin
			write_register({REG_INPUT_BITS, 2'b00}, CFG_W'(phase_in[p]));
			write_register({REG_OUTPUT_BITS, 2'b00}, CFG_W'(phase_out[p]));
			in_bits_reg = CFG_W'(phase_in[p]);
			out_bits_reg = CFG_W'(phase_out[p]);
			ib = used_bits(in_bits_reg, MAX_IN_BITS);
			ob = used_bits(out_bits_reg, MAX_OUT_BITS);
			// One phase runs with no idling on either side.
			send_idle_pct = (p == 5) ? 0 : 35;
			recv_idle_pct = (p == 5) ? 0 : 35;
			if (p == 0) begin
				// Four entries, three output bits. Writes at the edges of
				// both ranges, a write whose index and value are both bad
				// (the index error wins), reads in and out of range, queries
				// with zero, full and out-of-range masks, and junk kinds.
				queue_request('{REQ_WRITE, 8'd0, 8'd0, 8'd0, 8'd0}, ib, ob);
				queue_request('{REQ_WRITE, 8'd3, 8'd7, 8'd0, 8'd0}, ib, ob);
				queue_request('{REQ_WRITE, 8'd1, 8'd5, 8'd0, 8'd0}, ib, ob);
				queue_request('{REQ_WRITE, 8'd2, 8'd2, 8'd0, 8'd0}, ib, ob);
				queue_request('{REQ_WRITE, 8'd255, 8'd255, 8'd0, 8'd0}, ib, ob);
				queue_request('{REQ_WRITE, 8'd4, 8'd0, 8'd0, 8'd0}, ib, ob);
				queue_request('{REQ_WRITE, 8'd1, 8'd8, 8'd0, 8'd0}, ib, ob);
				queue_request('{REQ_WRITE, 8'd0, 8'd255, 8'd0, 8'd0}, ib, ob);
				queue_request('{REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0}, ib, ob);
				queue_request('{REQ_READ, 8'd3, 8'd0, 8'd0, 8'd0}, ib, ob);
				queue_request('{REQ_READ, 8'd255, 8'd0, 8'd0, 8'd0}, ib, ob);
				queue_request('{REQ_READ, 8'd4, 8'd0, 8'd0, 8'd0}, ib, ob);
				queue_request('{REQ_QUERY, 8'd0, 8'd0, 8'd0, 8'd0}, ib, ob);
				queue_request('{REQ_QUERY, 8'd0, 8'd0, 8'd3, 8'd7}, ib, ob);
				queue_request('{REQ_QUERY, 8'd0, 8'd0, 8'd1, 8'd2}, ib, ob);
				queue_request('{REQ_QUERY, 8'd0, 8'd0, 8'd4, 8'd0}, ib, ob);
				queue_request('{REQ_QUERY, 8'd0, 8'd0, 8'd0, 8'd8}, ib, ob);
				queue_request('{REQ_QUERY, 8'd0, 8'd0, 8'd255, 8'd255}, ib, ob);
				queue_request('{REQ_JUNK, 8'd255, 8'd255, 8'd255, 8'd255}, ib, ob);
				queue_request('{REQ_JUNK, 8'd0, 8'd0, 8'd0, 8'd0}, ib, ob);
			end
			for (int n = 0; n < phase_len[p]; n++) begin
				queue_request(make_request(ib, ob), ib, ob);
			end
			wait_drained();
			repeat (SETTLE_WAIT) @(posedge clk);
		end
		// Give a stray response time to show up before the verdict.
		repeat (DRAIN_WAIT) @(posedge clk);
		if (error_count == 0 && expected_answers.size() == 0) begin
			$display("sbox_linear_correlation: match");
		end else begin
			$display("sbox_linear_correlation: mismatch");
		end
		$finish;
	end

	// Request driver. A new item goes out only when the port is free, so a
	// stalled item holds its payload and valid never drops under a stall.
	// The answer for an item is worked out at the edge where it is taken,
	// from the payload the block actually saw.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || !req_stall) begin
			if (req_valid) begin
				expected_answers.insert(expected_answers.size(),
					apply_request('{req_type, table_index, entry_value, in_mask,
					out_mask}));
			end
			if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				outgoing = request_backlog.pop_front();
				req_type <= outgoing.kind;
				table_index <= outgoing.index;
				entry_value <= outgoing.value;
				in_mask <= outgoing.imask;
				out_mask <= outgoing.omask;
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Response monitor and receiver. Each item taken is compared with the
	// oldest waiting answer. Once, while plenty of requests are still queued,
	// the receiver holds off for a long stretch so that the block backs up
	// and stalls its request side.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				answers_seen++;
				if (expected_answers.size() == 0) begin
					$display("%0t: unexpected item: correlation %0d entry %0d error %0d",
						$time, correlation, entry_out, error_code);
					error_count++;
				end else begin
					oldest_answer = expected_answers.pop_front();
					if (correlation !== oldest_answer.corr) begin
						$display("%0t: correlation expected %0d, got %0d",
							$time, oldest_answer.corr, correlation);
						error_count++;
					end
					if (entry_out !== oldest_answer.entry) begin
						$display("%0t: entry_out expected %0d, got %0d",
							$time, oldest_answer.entry, entry_out);
						error_count++;
					end
					if (error_code !== oldest_answer.err) begin
						$display("%0t: error_code expected %0d, got %0d",
							$time, oldest_answer.err, error_code);
						error_count++;
					end
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (!hold_done && answers_seen > 150 && request_backlog.size() > 30) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Watchdog: ends the run if nothing moves on any port for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
					|| (psel && penable && pready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("sbox_linear_correlation: mismatch");
				$finish;
			end
		end
	end

endmodule
